// File: design/btpc_pkg.sv
// Shared types and constants for the barometric compensation block.
// No dependencies; imported by every module of the block.
package btpc_pkg;

	// Divider width, queue sizes and register map
	localparam int DIV_W = 32;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;
	localparam int ADDR_W = 6;

	localparam logic [2:0] REG_AC123 = 3'd0;
	localparam logic [2:0] REG_AC456 = 3'd1;
	localparam logic [2:0] REG_B1B2 = 3'd2;
	localparam logic [2:0] REG_MCMD = 3'd3;
	localparam logic [2:0] REG_OSS = 3'd4;

	// Compensation constants
	localparam logic signed [29:0] C_B6_OFS = 30'sd4000;
	localparam logic signed [44:0] C_B4_OFS = 45'sd32768;
	localparam logic [15:0] C_B7_SCALE = 16'd50000;
	localparam logic [11:0] C_P_SQ = 12'd3038;
	localparam logic signed [13:0] C_P_LIN = -14'sd7357;
	localparam logic signed [47:0] C_P_OFS = 48'sd3791;
	localparam logic [17:0] P_MAX = 18'd262143;

	// Calibration words unpacked from the configuration registers
	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} cal_t;

	// Transfer from the temperature front end to the pressure back end
	typedef struct packed {
		logic signed [29:0] b6;
		logic signed [15:0] temp;
		logic               err;
		logic [18:0]        up;
	} qent_t;

endpackage

// File: design/btpc_div.sv
// Pipelined unsigned divider, one quotient bit per stage.
// Depends on btpc_pkg for DIV_W; used by the front and back ends.
module btpc_div import btpc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [DIV_W-1:0] quo
);

	logic [DIV_W-1:0] rem_s [DIV_W];
	logic [DIV_W-1:0] nq_s  [DIV_W];
	logic [DIV_W-1:0] den_s [DIV_W];
	logic [DIV_W-1:0] r_in  [DIV_W];
	logic [DIV_W-1:0] n_in  [DIV_W];
	logic [DIV_W-1:0] d_in  [DIV_W];
	logic [DIV_W:0]   trial [DIV_W];
	logic [DIV_W:0]   diff  [DIV_W];

	// Feed each stage from the one before
	always_comb begin
		r_in[0] = '0;
		n_in[0] = num;
		d_in[0] = den;
		for (int i = 1; i < DIV_W; i++) begin
			r_in[i] = rem_s[i-1];
			n_in[i] = nq_s[i-1];
			d_in[i] = den_s[i-1];
		end
	end

	// Trial subtract per stage
	always_comb begin
		for (int i = 0; i < DIV_W; i++) begin
			trial[i] = {r_in[i], n_in[i][DIV_W-1]};
			diff[i] = trial[i] - {1'b0, d_in[i]};
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_W; i++) begin
				if (!diff[i][DIV_W]) begin
					rem_s[i] <= diff[i][DIV_W-1:0];
					nq_s[i] <= {n_in[i][DIV_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[i][DIV_W-1:0];
					nq_s[i] <= {n_in[i][DIV_W-2:0], 1'b0};
				end
				den_s[i] <= d_in[i];
			end
		end
	end

	assign quo = nq_s[DIV_W-1];

endmodule

// File: design/btpc_front.sv
// Front end: takes raw pairs, computes the temperature and B6.
// Depends on btpc_pkg and btpc_div; feeds btpc_fifo.
module btpc_front import btpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] raw_temp,
	input  logic [18:0] raw_press,
	output logic        push,
	output qent_t       push_data,
	input  logic        q_full
);

	typedef struct packed {
		logic signed [18:0] x1;
		logic               neg;
		logic               zero;
		logic [18:0]        up;
	} fside_t;

	logic               fe;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               vdiv_s [DIV_W];
	fside_t             side_s [DIV_W];
	logic [15:0]        ut_s1;
	logic [18:0]        up_s1, up_s2;
	logic signed [33:0] prod_s2;
	logic signed [16:0] dt;
	logic signed [33:0] prod_c;
	logic signed [18:0] x1;
	logic signed [19:0] den;
	logic signed [26:0] num;
	fside_t             side_s3;
	logic [26:0]        nmag_s3;
	logic [19:0]        dmag_s3;
	logic [DIV_W-1:0]   quo;
	logic signed [27:0] x2;
	logic signed [28:0] b5;
	logic signed [29:0] b5r;
	logic signed [25:0] tpre;
	logic signed [15:0] tsat;
	qent_t              ent_s4;

	// Stall the whole pipe while the queue cannot take its last stage
	assign fe = !(v_s4 && q_full);
	assign in_stall = !fe;
	assign push = v_s4 && !q_full;
	assign push_data = ent_s4;

	// Stage 1: register the transfer
	always_ff @(posedge clk) begin
		if (fe) begin
			ut_s1 <= raw_temp;
			up_s1 <= raw_press;
		end
	end

	// Stage 2: (UT - AC6) * AC5
	assign dt = $signed({1'b0, ut_s1}) - $signed({1'b0, cal.ac6});
	assign prod_c = dt * $signed({1'b0, cal.ac5});

	always_ff @(posedge clk) begin
		if (fe) begin
			prod_s2 <= prod_c;
			up_s2 <= up_s1;
		end
	end

	// Stage 3: X1, divisor X1 + MD, magnitudes for the divider
	assign x1 = prod_s2[33:15];
	assign den = 20'(x1) + 20'($signed(cal.md));
	assign num = $signed({cal.mc, 11'b0});

	always_ff @(posedge clk) begin
		if (fe) begin
			side_s3.x1 <= x1;
			side_s3.neg <= cal.mc[15] ^ den[19];
			side_s3.zero <= (den == 20'sd0);
			side_s3.up <= up_s2;
			nmag_s3 <= num[26] ? 27'(-num) : num;
			dmag_s3 <= den[19] ? 20'(-den) : den;
		end
	end

	btpc_div u_div (
		.clk (clk),
		.en  (fe),
		.num ({5'b0, nmag_s3}),
		.den ({12'b0, dmag_s3}),
		.quo (quo)
	);

	// Carry side data alongside the divider
	always_ff @(posedge clk) begin
		if (fe) begin
			side_s[0] <= side_s3;
			for (int i = 1; i < DIV_W; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Stage 4: B5, temperature and B6
	assign x2 = side_s[DIV_W-1].neg ? -$signed({1'b0, quo[26:0]})
		: $signed({1'b0, quo[26:0]});
	assign b5 = 29'(side_s[DIV_W-1].x1) + 29'(x2);
	assign b5r = 30'(b5) + 30'sd8;
	assign tpre = 26'(b5r >>> 4);

	always_comb begin
		if (tpre > 26'sd32767) begin
			tsat = 16'sh7fff;
		end else if (tpre < -26'sd32768) begin
			tsat = -16'sh8000;
		end else begin
			tsat = tpre[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			ent_s4.b6 <= 30'(b5) - C_B6_OFS;
			ent_s4.temp <= tsat;
			ent_s4.err <= side_s[DIV_W-1].zero;
			ent_s4.up <= side_s[DIV_W-1].up;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < DIV_W; i++) begin
				vdiv_s[i] <= 1'b0;
			end
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vdiv_s[0] <= v_s3;
			for (int i = 1; i < DIV_W; i++) begin
				vdiv_s[i] <= vdiv_s[i-1];
			end
			v_s4 <= vdiv_s[DIV_W-1];
		end
	end

endmodule

// File: design/btpc_fifo.sv
// Short queue between the temperature front end and pressure back end.
// Depends on btpc_pkg for the entry type and depth.
module btpc_fifo import btpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	output logic  not_empty,
	input  logic  pop,
	output qent_t head
);

	qent_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q, rp_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rp_q];

	// Store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/btpc_back.sv
// Back end: pressure compensation from B6 and UP, output register.
// Depends on btpc_pkg and btpc_div; drains btpc_fifo.
module btpc_back import btpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        q_valid,
	input  qent_t       q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] temp_tenths,
	output logic [17:0] press_pa,
	output logic        div_error
);

	typedef struct packed {
		logic signed [15:0] temp;
		logic               err;
		logic [18:0]        up;
	} bcar_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic               err;
		logic               big;
	} bside_t;

	logic               be;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic               vdiv_s [DIV_W];
	logic               out_valid_q;
	logic [15:0]        temp_q;
	logic [17:0]        press_q;
	logic               err_q;

	bcar_t              car_s1, car_s2, car_s3, car_s4, car_s5, car_s6;
	logic [28:0]        abs_b6;
	logic [57:0]        sqf_s1;
	logic signed [45:0] ac2b6_s1, ac2b6_s2, ac2b6_s3;
	logic signed [45:0] ac3b6_s1, ac3b6_s2, ac3b6_s3;
	logic [45:0]        sq;
	logic signed [23:0] sq_hi, sq_lo;
	logic signed [39:0] pb2h_s2, pb2l_s2, pb1h_s2, pb1l_s2;
	logic signed [61:0] b2sq_s3, b1sq_s3;
	logic signed [46:0] t3;
	logic signed [51:0] x3_s4;
	logic signed [44:0] x3b_s4;
	logic signed [52:0] a5;
	logic signed [56:0] v_c;
	logic signed [56:0] b3n_s5;
	logic [31:0]        m4_s5;
	logic [31:0]        b3lo_s6;
	logic [47:0]        prod4_c;
	logic [47:0]        prod4_s6;
	logic [31:0]        b4;
	logic [31:0]        dif7;
	logic [15:0]        scale;
	logic [31:0]        b7;
	logic [31:0]        ndiv_s7;
	logic [31:0]        b4_s7;
	bside_t             side_s7;
	bside_t             side_s [DIV_W];
	logic [DIV_W-1:0]   quo;
	logic [32:0]        pu;
	logic [24:0]        p8;
	logic signed [47:0] m73_c;
	logic [49:0]        sq2_s8;
	logic signed [47:0] m73_s8, m73_s9;
	logic [32:0]        pu_s8, pu_s9, pu_s10;
	bside_t             sd_s8, sd_s9, sd_s10;
	logic [36:0]        ph_s9, pl_s9;
	logic [61:0]        x1sum;
	logic [45:0]        x1p;
	logic signed [31:0] x2p;
	logic signed [47:0] s_s10;
	logic signed [47:0] pf;
	logic [17:0]        psat;

	// Stall the whole pipe while a result waits on the output
	assign be = !(out_valid_q && out_stall);
	assign pop = be && q_valid;

	// Stage 1: B6 squared, AC2*B6, AC3*B6
	assign abs_b6 = q_data.b6[29] ? 29'(-q_data.b6) : q_data.b6[28:0];

	always_ff @(posedge clk) begin
		if (be) begin
			sqf_s1 <= abs_b6 * abs_b6;
			ac2b6_s1 <= $signed(cal.ac2) * q_data.b6;
			ac3b6_s1 <= $signed(cal.ac3) * q_data.b6;
			car_s1.temp <= q_data.temp;
			car_s1.err <= q_data.err;
			car_s1.up <= q_data.up;
		end
	end

	// Stage 2: partial products of B2*sq and B1*sq
	assign sq = sqf_s1[57:12];
	assign sq_hi = $signed({1'b0, sq[45:23]});
	assign sq_lo = $signed({1'b0, sq[22:0]});

	always_ff @(posedge clk) begin
		if (be) begin
			pb2h_s2 <= $signed(cal.b2) * sq_hi;
			pb2l_s2 <= $signed(cal.b2) * sq_lo;
			pb1h_s2 <= $signed(cal.b1) * sq_hi;
			pb1l_s2 <= $signed(cal.b1) * sq_lo;
			ac2b6_s2 <= ac2b6_s1;
			ac3b6_s2 <= ac3b6_s1;
			car_s2 <= car_s1;
		end
	end

	// Stage 3: combine partial products
	always_ff @(posedge clk) begin
		if (be) begin
			b2sq_s3 <= (62'(pb2h_s2) <<< 23) + 62'(pb2l_s2);
			b1sq_s3 <= (62'(pb1h_s2) <<< 23) + 62'(pb1l_s2);
			ac2b6_s3 <= ac2b6_s2;
			ac3b6_s3 <= ac3b6_s2;
			car_s3 <= car_s2;
		end
	end

	// Stage 4: X3 for B3 and X3 for B4
	assign t3 = 47'(ac3b6_s3 >>> 13) + 47'(b1sq_s3 >>> 16) + 47'sd2;

	always_ff @(posedge clk) begin
		if (be) begin
			x3_s4 <= 52'(b2sq_s3 >>> 11) + 52'(ac2b6_s3 >>> 11);
			x3b_s4 <= 45'(t3 >>> 2);
			car_s4 <= car_s3;
		end
	end

	// Stage 5: B3 numerator, B4 multiplicand
	assign a5 = 53'(x3_s4) + 53'($signed({cal.ac1, 2'b00}));
	assign v_c = (57'(a5) <<< cal.oss) + 57'sd2;

	always_ff @(posedge clk) begin
		if (be) begin
			b3n_s5 <= v_c;
			m4_s5 <= 32'(x3b_s4 + C_B4_OFS);
			car_s5 <= car_s4;
		end
	end

	// Stage 6: B3 truncated toward zero, AC4 product
	assign prod4_c = cal.ac4 * m4_s5;

	always_ff @(posedge clk) begin
		if (be) begin
			b3lo_s6 <= b3n_s5[33:2] + 32'(b3n_s5[56] && (b3n_s5[1:0] != 2'b00));
			prod4_s6 <= prod4_c;
			car_s6 <= car_s5;
		end
	end

	// Stage 7: B4, B7 and the divider operands
	assign b4 = prod4_s6[46:15];
	assign dif7 = {13'b0, car_s6.up} - b3lo_s6;
	assign scale = C_B7_SCALE >> cal.oss;
	assign b7 = dif7 * scale;

	always_ff @(posedge clk) begin
		if (be) begin
			ndiv_s7 <= b7[31] ? b7 : {b7[30:0], 1'b0};
			b4_s7 <= b4;
			side_s7.big <= b7[31];
			side_s7.err <= car_s6.err || (b4 == 32'd0);
			side_s7.temp <= car_s6.temp;
		end
	end

	btpc_div u_div (
		.clk (clk),
		.en  (be),
		.num (ndiv_s7),
		.den (b4_s7),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (be) begin
			side_s[0] <= side_s7;
			for (int i = 1; i < DIV_W; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Stage 8: p, (p >> 8) squared, linear term
	assign pu = side_s[DIV_W-1].big ? {quo, 1'b0} : {1'b0, quo};
	assign p8 = pu[32:8];
	assign m73_c = C_P_LIN * $signed({1'b0, pu});

	always_ff @(posedge clk) begin
		if (be) begin
			sq2_s8 <= p8 * p8;
			m73_s8 <= m73_c;
			pu_s8 <= pu;
			sd_s8 <= side_s[DIV_W-1];
		end
	end

	// Stage 9: split square times 3038
	always_ff @(posedge clk) begin
		if (be) begin
			ph_s9 <= sq2_s8[49:25] * C_P_SQ;
			pl_s9 <= sq2_s8[24:0] * C_P_SQ;
			m73_s9 <= m73_s8;
			pu_s9 <= pu_s8;
			sd_s9 <= sd_s8;
		end
	end

	// Stage 10: correction sum
	assign x1sum = {ph_s9, 25'b0} + 62'(pl_s9);
	assign x1p = 46'(x1sum >> 16);
	assign x2p = 32'(m73_s9 >>> 16);

	always_ff @(posedge clk) begin
		if (be) begin
			s_s10 <= $signed({2'b0, x1p}) + 48'(x2p) + C_P_OFS;
			pu_s10 <= pu_s9;
			sd_s10 <= sd_s9;
		end
	end

	// Final pressure and saturation
	assign pf = $signed({15'b0, pu_s10}) + (s_s10 >>> 4);

	always_comb begin
		if (pf < 48'sd0) begin
			psat = '0;
		end else if (pf > $signed({30'b0, P_MAX})) begin
			psat = P_MAX;
		end else begin
			psat = pf[17:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (be) begin
			temp_q <= sd_s10.err ? 16'd0 : sd_s10.temp;
			press_q <= sd_s10.err ? 18'd0 : psat;
			err_q <= sd_s10.err;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIV_W; i++) begin
				vdiv_s[i] <= 1'b0;
			end
		end else if (be) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			vdiv_s[0] <= v_s7;
			for (int i = 1; i < DIV_W; i++) begin
				vdiv_s[i] <= vdiv_s[i-1];
			end
			v_s8 <= vdiv_s[DIV_W-1];
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			out_valid_q <= v_s10;
		end
	end

	assign out_valid = out_valid_q;
	assign temp_tenths = temp_q;
	assign press_pa = press_q;
	assign div_error = err_q;

endmodule

// File: design/baro_temp_press_compensation.sv
// Barometric temperature and pressure compensation, top level.
// Depends on btpc_pkg, btpc_front, btpc_fifo and btpc_back.
//
// Takes one raw temperature and pressure pair per transfer and returns the
// compensated temperature in tenths of a degree and pressure in pascals,
// one result per pair. A new pair is taken every clock cycle unless in_stall
// is high: both dividers are fully pipelined at one quotient bit per stage,
// so throughput is one item a cycle while nothing stalls. Each pair passes
// through the temperature front end, the queue and the pressure back end,
// including its output register. div_error flags a zero X1 + MD or B4, with
// both results then zero. Calibration sits in 64-bit APB registers at byte
// addresses 8*i; write them only while no item is in flight.
module baro_temp_press_compensation import btpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       raw_temp,
	input  logic [18:0]       raw_press,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       temp_tenths,
	output logic [17:0]       press_pa,
	output logic              div_error
);

	logic [47:0] ac123_q;
	logic [47:0] ac456_q;
	logic [31:0] b1b2_q;
	logic [31:0] mcmd_q;
	logic [1:0]  oss_q;
	logic [2:0]  idx;
	logic        wr;
	cal_t        cal;
	logic        push, q_full, q_valid, pop;
	qent_t       push_data, head;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac123_q <= '0;
			ac456_q <= '0;
			b1b2_q <= '0;
			mcmd_q <= '0;
			oss_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_AC123: ac123_q <= pwdata[47:0];
				REG_AC456: ac456_q <= pwdata[47:0];
				REG_B1B2:  b1b2_q <= pwdata[31:0];
				REG_MCMD:  mcmd_q <= pwdata[31:0];
				REG_OSS:   oss_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_AC123: prdata = {16'b0, ac123_q};
			REG_AC456: prdata = {16'b0, ac456_q};
			REG_B1B2:  prdata = {32'b0, b1b2_q};
			REG_MCMD:  prdata = {32'b0, mcmd_q};
			REG_OSS:   prdata = {62'b0, oss_q};
			default:   prdata = '0;
		endcase
	end

	// Unpack calibration words
	assign cal.ac1 = ac123_q[47:32];
	assign cal.ac2 = ac123_q[31:16];
	assign cal.ac3 = ac123_q[15:0];
	assign cal.ac4 = ac456_q[47:32];
	assign cal.ac5 = ac456_q[31:16];
	assign cal.ac6 = ac456_q[15:0];
	assign cal.b1 = b1b2_q[31:16];
	assign cal.b2 = b1b2_q[15:0];
	assign cal.mc = mcmd_q[31:16];
	assign cal.md = mcmd_q[15:0];
	assign cal.oss = oss_q;

	btpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.raw_temp  (raw_temp),
		.raw_press (raw_press),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	btpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (pop),
		.head      (head)
	);

	btpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cal         (cal),
		.q_valid     (q_valid),
		.q_data      (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.temp_tenths (temp_tenths),
		.press_pa    (press_pa),
		.div_error   (div_error)
	);

endmodule

// File: tb/testbench.sv
// Self-checking bench for the barometric temperature and pressure compensation block.
// Depends on btpc_pkg and baro_temp_press_compensation; drives the APB port and both
// streaming channels, predicts each result and checks it field by field.
`timescale 1ns / 100ps

module testbench;
	import btpc_pkg::*;

	typedef struct {
		logic [15:0] ut;
		logic [18:0] up;
	} sample_t;

	typedef struct {
		logic [15:0] temp;
		logic [17:0] press;
		logic        err;
	} reading_t;

	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] raw_temp = '0;
	logic [18:0] raw_press = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] temp_tenths;
	logic [17:0] press_pa;
	logic div_error;

	// Calibration copy held by the bench
	logic [47:0] cal_ac123 = '0;
	logic [47:0] cal_ac456 = '0;
	logic [31:0] cal_b1b2 = '0;
	logic [31:0] cal_mcmd = '0;
	logic [1:0] cal_oss = '0;

	sample_t pending_samples[$];
	reading_t expected_readings[$];
	int mismatches = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	baro_temp_press_compensation u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_temp(raw_temp), .raw_press(raw_press),
		.out_valid(out_valid), .out_stall(out_stall),
		.temp_tenths(temp_tenths), .press_pa(press_pa), .div_error(div_error)
	);

	always #1 clk = ~clk;

	// Integer compensation from the current calibration
	function automatic reading_t compensate(input logic [15:0] ut_in, input logic [18:0] up_in);
		reading_t res;
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
		longint x1, x2, x3, b5, b6, b3, t, sq, p, corr;
		logic [63:0] a4u, prod, pu;
		logic [31:0] xs, b4, b7, diff, scale;
		int oss;
		res.temp = '0;
		res.press = '0;
		res.err = 1'b1;
		ac1 = longint'($signed(cal_ac123[47:32]));
		ac2 = longint'($signed(cal_ac123[31:16]));
		ac3 = longint'($signed(cal_ac123[15:0]));
		ac4 = longint'({48'd0, cal_ac456[47:32]});
		ac5 = longint'({48'd0, cal_ac456[31:16]});
		ac6 = longint'({48'd0, cal_ac456[15:0]});
		b1 = longint'($signed(cal_b1b2[31:16]));
		b2 = longint'($signed(cal_b1b2[15:0]));
		mc = longint'($signed(cal_mcmd[31:16]));
		md = longint'($signed(cal_mcmd[15:0]));
		oss = int'(cal_oss);
		ut = longint'({48'd0, ut_in});

		x1 = ((ut - ac6) * ac5) >>> 15;
		if (x1 + md == 0)
			return res;
		x2 = (mc * 2048) / (x1 + md);
		b5 = x1 + x2;
		t = (b5 + 8) >>> 4;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;

		b6 = b5 - 4000;
		sq = (b6 * b6) >>> 12;
		x1 = (b2 * sq) >>> 11;
		x2 = (ac2 * b6) >>> 11;
		x3 = x1 + x2;
		b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
		x1 = (ac3 * b6) >>> 13;
		x2 = (b1 * sq) >>> 16;
		x3 = (x1 + x2 + 2) >>> 2;
		a4u = ac4;
		xs = 32'(x3 + 32768);
		prod = a4u * {32'd0, xs};
		b4 = prod[46:15];
		if (b4 == 0)
			return res;
		diff = {13'd0, up_in} - b3[31:0];
		scale = 32'd50000 >> oss;
		b7 = diff * scale;
		if (b7 < 32'h8000_0000)
			pu = ({32'd0, b7} * 64'd2) / {32'd0, b4};
		else
			pu = ({32'd0, b7} / {32'd0, b4}) * 64'd2;
		p = pu;

		x1 = (p >>> 8) * (p >>> 8);
		x1 = (x1 * 3038) >>> 16;
		x2 = (-7357 * p) >>> 16;
		corr = (x1 + x2 + 3791) >>> 4;
		p = p + corr;
		if (p < 0) p = 0;
		if (p > 262143) p = 262143;

		res.temp = t[15:0];
		res.press = p[17:0];
		res.err = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Sender: present queued samples, hold the payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_readings.push_back(compensate(raw_temp, raw_press));
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
					sample_t s;
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					raw_temp <= s.ut;
					raw_press <= s.up;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random idling plus one long hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_done && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 14);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected transfer, temp", $signed(temp_tenths), 0);
			end else begin
				reading_t e;
				e = expected_readings.pop_front();
				if (temp_tenths !== e.temp)
					report_mismatch("temp_tenths", $signed(temp_tenths), $signed(e.temp));
				if (press_pa !== e.press)
					report_mismatch("press_pa", press_pa, e.press);
				if (div_error !== e.err)
					report_mismatch("div_error", div_error, e.err);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AC123: cal_ac123 = value[47:0];
			REG_AC456: cal_ac456 = value[47:0];
			REG_B1B2: cal_b1b2 = value[31:0];
			REG_MCMD: cal_mcmd = value[31:0];
			REG_OSS: cal_oss = value[1:0];
			default: ;
		endcase
	endtask

	task automatic load_cal(input logic [47:0] a123, input logic [47:0] a456,
			input logic [31:0] bb, input logic [31:0] mm, input logic [1:0] os);
		write_reg(REG_AC123, {16'd0, a123});
		write_reg(REG_AC456, {16'd0, a456});
		write_reg(REG_B1B2, {32'd0, bb});
		write_reg(REG_MCMD, {32'd0, mm});
		write_reg(REG_OSS, {62'd0, os});
	endtask

	task automatic load_datasheet(input logic [1:0] os);
		load_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, os);
	endtask

	task automatic queue_sample(input logic [15:0] ut, input logic [18:0] up);
		sample_t s;
		s.ut = ut;
		s.up = up;
		pending_samples.push_back(s);
	endtask

	// Drain everything in flight, then let the pipeline settle
	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 60)
				queue_sample(16'($urandom_range(35000, 20000)),
					19'($urandom_range(30000, 15000) << cal_oss));
			else
				queue_sample(16'($urandom), 19'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: datasheet example and field extremes
		load_datasheet(2'd0);
		queue_sample(16'd27898, 19'd23843);
		queue_sample(16'd0, 19'd0);
		queue_sample(16'hFFFF, 19'h7FFFF);
		queue_sample(16'd0, 19'h7FFFF);
		queue_sample(16'hFFFF, 19'd0);
		queue_sample(16'h5555, 19'h2AAAA);
		queue_sample(16'hAAAA, 19'h55555);
		drain();
		// Zero temperature divisor: all calibration zero
		load_cal('0, '0, '0, '0, 2'd0);
		queue_sample(16'd27898, 19'd23843);
		queue_sample(16'hFFFF, 19'h7FFFF);
		drain();
		// Zero pressure divisor: AC4 zero
		load_cal({16'd408, -16'sd72, -16'sd14383}, {16'd0, 16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd3);
		queue_sample(16'd27898, 19'd23843);
		queue_sample(16'd0, 19'h7FFFF);
		drain();
		// All-ones calibration, maximum oversampling
		load_cal('1, '1, '1, '1, 2'd3);
		queue_sample(16'd0, 19'd0);
		queue_sample(16'hFFFF, 19'h7FFFF);
		queue_sample(16'd27898, 19'd23843);
		drain();

		// Random phases across calibration sets and oversampling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: load_datasheet(2'(ph % 4));
				1: load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					$urandom, $urandom, 2'(ph % 4));
				2: load_cal({16'(408 + $urandom_range(200)), -16'sd72, -16'sd14383},
					{16'(32741 - $urandom_range(800)), 16'd32757, 16'(23153 + $urandom_range(999))},
					{16'd6190, 16'($urandom_range(20))}, {-16'sd8711, 16'd2868}, 2'(ph % 4));
				default: load_datasheet(2'(ph % 4));
			endcase
			calm = (ph == 2);
			hold_req = (ph == 4);
			queue_random(230);
			drain();
			calm = 1'b0;
		end

		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

// File: filelist.f
design/btpc_pkg.sv
design/btpc_div.sv
design/btpc_front.sv
design/btpc_fifo.sv
design/btpc_back.sv
design/baro_temp_press_compensation.sv
tb/testbench.sv
